// ===== rtl/core/dual_comb_reverb_core_assert.svh =====
// assertion macros shared by the reverb core modules
// both forms sample on the rising edge of clk and are off while arst_n is low
`ifndef DUAL_COMB_REVERB_CORE_ASSERT_SVH
`define DUAL_COMB_REVERB_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expression holds at every edge
`define DCR_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequence holds at the edge after the antecedent
`define DCR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DCR_ASSERT_ALWAYS(label, expr, msg)
`define DCR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/dcr_pkg.sv =====
package dcr_pkg;

	// delay line geometry
	localparam int DELAY_DEPTH = 8192;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);

	// field widths
	localparam int SAMPLE_W   = 16;
	localparam int DELAY_W    = 13;
	localparam int GAIN_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// arithmetic constants
	localparam int FB_SHIFT    = 8;
	localparam int SCALE_MUL   = 11;
	localparam int SCALE_SHIFT = 6;
	// reciprocal of 6 scaled by 2^18, exact for magnitudes below 2^17
	localparam int DIV6_RECIP  = 43691;
	localparam int DIV6_SHIFT  = 18;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_A    = 3'd0,
		REG_DELAY_B    = 3'd1,
		REG_FB_GAIN    = 3'd2,
		REG_LP_EN      = 3'd3,
		REG_SCALE_MODE = 3'd4
	} cfg_reg_t;

	// read issue for a new word entering the first stage
	typedef struct packed {
		logic   accept;
		addr_t  widx;
		logic   wrapped;
	} issue_t;

	// word held in the first stage, written back when it advances
	typedef struct packed {
		logic    advance;
		addr_t   widx;
		sample_t mid;
		logic    silent_in;
	} exec_t;

	// clamp an 18-bit signed value to the sample range
	function automatic sample_t sat16(input logic signed [SAMPLE_W+1:0] x);
		logic signed [SAMPLE_W+1:0] hi;
		logic signed [SAMPLE_W+1:0] lo;
		hi = (SAMPLE_W+2)'(32767);
		lo = -(SAMPLE_W+2)'(32768);
		if (x > hi) begin
			return sample_t'(hi);
		end else if (x < lo) begin
			return sample_t'(lo);
		end
		return x[SAMPLE_W-1:0];
	endfunction

endpackage

// ===== rtl/core/dcr_in_if.sv =====
interface dcr_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [dcr_pkg::SAMPLE_W-1:0] left_in;
	logic signed [dcr_pkg::SAMPLE_W-1:0] right_in;
	logic                               last_in;

	modport source (output valid, output left_in, output right_in, output last_in,
		input ready);
	modport sink (input valid, input left_in, input right_in, input last_in,
		output ready);
endinterface

// ===== rtl/core/dcr_out_if.sv =====
interface dcr_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [dcr_pkg::SAMPLE_W-1:0] left_out;
	logic signed [dcr_pkg::SAMPLE_W-1:0] right_out;
	logic                               last_out;

	modport source (output valid, output left_out, output right_out, output last_out,
		input ready);
	modport sink (input valid, input left_out, input right_out, input last_out,
		output ready);
endinterface

// ===== rtl/core/dcr_ram.sv =====
module dcr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/dcr_comb.sv =====
`include "dual_comb_reverb_core_assert.svh"

module dcr_comb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dcr_pkg::DELAY_W-1:0]   delay,
	input  logic [dcr_pkg::GAIN_W-1:0]    gain,
	input  logic                          lp_en,
	input  dcr_pkg::issue_t               issue,
	input  dcr_pkg::exec_t                exec,
	output dcr_pkg::sample_t              val
);

	dcr_pkg::addr_t   rd_addr;
	logic             rd_ok;
	logic             fwd_hit;
	logic             vld_s1;
	logic             fwd_s1;
	dcr_pkg::sample_t fwd_data_s1;
	dcr_pkg::sample_t ram_q;
	dcr_pkg::sample_t delayed;
	dcr_pkg::sample_t smooth_q;
	dcr_pkg::sample_t fbv;
	logic signed [dcr_pkg::SAMPLE_W+dcr_pkg::GAIN_W:0]   fb_prod;
	logic signed [dcr_pkg::SAMPLE_W:0]                   fb_term;
	logic signed [dcr_pkg::SAMPLE_W+1:0]                 pre_sat;
	logic signed [dcr_pkg::SAMPLE_W:0]                   lp_sum;
	logic             silent;

	// read address trails the write index by the delay
	assign rd_addr = issue.widx - dcr_pkg::addr_t'(delay);
	// entries not yet written since reset read as zero
	assign rd_ok   = issue.wrapped || (rd_addr < issue.widx);
	// read of the entry being written back at the same edge
	assign fwd_hit = exec.advance && (exec.widx == rd_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (issue.accept) begin
			vld_s1 <= rd_ok;
			fwd_s1 <= fwd_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (issue.accept) begin
			fwd_data_s1 <= val;
		end
	end

	dcr_ram #(
		.WIDTH (dcr_pkg::SAMPLE_W),
		.DEPTH (dcr_pkg::DELAY_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (exec.advance),
		.waddr (exec.widx),
		.wdata (val),
		.re    (issue.accept),
		.raddr (rd_addr),
		.rdata (ram_q)
	);

	// delayed sample with bypass and fill masking
	always_comb begin
		if (fwd_s1) begin
			delayed = fwd_data_s1;
		end else if (vld_s1) begin
			delayed = ram_q;
		end else begin
			delayed = '0;
		end
	end

	// feedback term, floor shift by taking the upper bits
	assign fb_prod = $signed({1'b0, gain}) * delayed;
	assign fb_term = fb_prod[dcr_pkg::SAMPLE_W+dcr_pkg::GAIN_W:dcr_pkg::FB_SHIFT];
	assign pre_sat = {{2{exec.mid[dcr_pkg::SAMPLE_W-1]}}, exec.mid} +
		{fb_term[dcr_pkg::SAMPLE_W], fb_term};
	assign fbv     = dcr_pkg::sat16(pre_sat);

	// two-tap average low-pass
	assign lp_sum = {smooth_q[dcr_pkg::SAMPLE_W-1], smooth_q} +
		{fbv[dcr_pkg::SAMPLE_W-1], fbv};

	assign silent = exec.silent_in && (delayed == '0);

	always_comb begin
		if (silent) begin
			val = '0;
		end else if (lp_en) begin
			val = lp_sum[dcr_pkg::SAMPLE_W:1];
		end else begin
			val = fbv;
		end
	end

	// low-pass memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
		end else if (exec.advance) begin
			if (silent) begin
				smooth_q <= '0;
			end else if (lp_en) begin
				smooth_q <= fbv;
			end
		end
	end

	`DCR_ASSERT_ALWAYS(a_fwd_valid, !fwd_s1 || vld_s1, "bypass taken on an unwritten entry")
	`DCR_ASSERT_NEXT(a_zero_delay_miss, issue.accept && !issue.wrapped && (rd_addr == issue.widx), !vld_s1, "full-depth read marked valid before wrap")
	`DCR_ASSERT_NEXT(a_silent_clear, exec.advance && silent, smooth_q == '0, "silence did not clear low-pass memory")

endmodule

// ===== rtl/core/dual_comb_reverb_core.sv =====
// channel   dir  fields                          handshake
// in_ch     in   left_in, right_in, last_in      valid/ready
// out_ch    out  left_out, right_out, last_out   valid/ready
// cfg       in   cfg_idx, cfg_data               cfg_we, no wait
//
// three stages: line read issue, comb and write-back, scale and mix; a word goes from
// stage 1 via stage 2 to the output register. While output words are taken, one word per
// cycle is sustained, set by one read and one write per cycle on each delay line memory.
// delay lines are not swept after reset: a fill flag on the write index makes entries not
// yet written read as zero, so words are taken from the first cycle out of reset.
// ready drops only when every stage holds a word and the output word is not taken.
`include "dual_comb_reverb_core_assert.svh"

module dual_comb_reverb_core (
	input  logic                            clk,
	input  logic                            arst_n,
	dcr_in_if.sink                          in_ch,
	dcr_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [dcr_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [dcr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	logic [dcr_pkg::DELAY_W-1:0] delay_a_q;
	logic [dcr_pkg::DELAY_W-1:0] delay_b_q;
	logic [dcr_pkg::GAIN_W-1:0]  gain_q;
	logic                        lp_en_q;
	logic                        scale_mode_q;

	// write index and fill flag
	dcr_pkg::addr_t widx_q;
	logic           wrapped_q;

	// stage control
	logic in_acc;
	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;
	logic v_s1;
	logic v_s2;
	logic v_s3;

	// stage 1 payload
	dcr_pkg::sample_t left_s1;
	dcr_pkg::sample_t right_s1;
	logic             last_s1;
	dcr_pkg::sample_t mid_s1;
	logic             silent_s1;
	dcr_pkg::addr_t   widx_s1;

	// stage 2 payload
	dcr_pkg::sample_t                  left_s2;
	dcr_pkg::sample_t                  right_s2;
	logic                              last_s2;
	logic signed [dcr_pkg::SAMPLE_W:0] sum_s2;

	// stage 3 payload
	dcr_pkg::sample_t left_s3;
	dcr_pkg::sample_t right_s3;
	logic             last_s3;

	logic signed [dcr_pkg::SAMPLE_W:0] in_sum;
	dcr_pkg::issue_t                   issue;
	dcr_pkg::exec_t                    exec;
	dcr_pkg::sample_t                  val_a;
	dcr_pkg::sample_t                  val_b;

	logic signed [dcr_pkg::SAMPLE_W+5:0]   mul11;
	logic                                  neg;
	logic [dcr_pkg::SAMPLE_W:0]            mag;
	logic [2*dcr_pkg::SAMPLE_W:0]          div_prod;
	logic [dcr_pkg::SAMPLE_W-2:0]          quot;
	dcr_pkg::sample_t                      scaled;
	logic signed [dcr_pkg::SAMPLE_W+1:0]   left_mix;
	logic signed [dcr_pkg::SAMPLE_W+1:0]   right_mix;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_a_q    <= dcr_pkg::DELAY_W'(1);
			delay_b_q    <= dcr_pkg::DELAY_W'(1);
			gain_q       <= '0;
			lp_en_q      <= 1'b1;
			scale_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (dcr_pkg::cfg_reg_t'(cfg_idx))
				dcr_pkg::REG_DELAY_A: begin
					delay_a_q <= cfg_data[dcr_pkg::DELAY_W-1:0];
				end
				dcr_pkg::REG_DELAY_B: begin
					delay_b_q <= cfg_data[dcr_pkg::DELAY_W-1:0];
				end
				dcr_pkg::REG_FB_GAIN: begin
					gain_q <= cfg_data[dcr_pkg::GAIN_W-1:0];
				end
				dcr_pkg::REG_LP_EN: begin
					lp_en_q <= cfg_data[0];
				end
				dcr_pkg::REG_SCALE_MODE: begin
					scale_mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// handshake chain
	assign rdy_s3      = !v_s3 || out_ch.ready;
	assign rdy_s2      = !v_s2 || rdy_s3;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign in_ch.ready = rdy_s1;
	assign in_acc      = in_ch.valid && rdy_s1;

	// write index advances once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q    <= '0;
			wrapped_q <= 1'b0;
		end else if (in_acc) begin
			widx_q <= widx_q + dcr_pkg::addr_t'(1);
			if (widx_q == dcr_pkg::addr_t'(dcr_pkg::DELAY_DEPTH - 1)) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	// mid value, floor halving
	assign in_sum = {in_ch.left_in[dcr_pkg::SAMPLE_W-1], in_ch.left_in} +
		{in_ch.right_in[dcr_pkg::SAMPLE_W-1], in_ch.right_in};

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			left_s1   <= in_ch.left_in;
			right_s1  <= in_ch.right_in;
			last_s1   <= in_ch.last_in;
			mid_s1    <= in_sum[dcr_pkg::SAMPLE_W:1];
			silent_s1 <= (in_ch.left_in == '0) && (in_ch.right_in == '0);
			widx_s1   <= widx_q;
		end
	end

	assign issue = '{accept: in_acc, widx: widx_q, wrapped: wrapped_q};
	assign exec  = '{advance: v_s1 && rdy_s2, widx: widx_s1, mid: mid_s1,
		silent_in: silent_s1};

	// the two comb filters
	dcr_comb u_comb_a (
		.clk    (clk),
		.arst_n (arst_n),
		.delay  (delay_a_q),
		.gain   (gain_q),
		.lp_en  (lp_en_q),
		.issue  (issue),
		.exec   (exec),
		.val    (val_a)
	);

	dcr_comb u_comb_b (
		.clk    (clk),
		.arst_n (arst_n),
		.delay  (delay_b_q),
		.gain   (gain_q),
		.lp_en  (lp_en_q),
		.issue  (issue),
		.exec   (exec),
		.val    (val_b)
	);

	// stage 2 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			left_s2  <= left_s1;
			right_s2 <= right_s1;
			last_s2  <= last_s1;
			sum_s2   <= {val_a[dcr_pkg::SAMPLE_W-1], val_a} +
				{val_b[dcr_pkg::SAMPLE_W-1], val_b};
		end
	end

	// shift scaling, floor
	assign mul11 = {{5{sum_s2[dcr_pkg::SAMPLE_W]}}, sum_s2} *
		(dcr_pkg::SAMPLE_W+6)'(dcr_pkg::SCALE_MUL);

	// divide by six toward zero through the reciprocal
	assign neg      = sum_s2[dcr_pkg::SAMPLE_W];
	assign mag      = neg ? (dcr_pkg::SAMPLE_W+1)'(-sum_s2) : (dcr_pkg::SAMPLE_W+1)'(sum_s2);
	assign div_prod = mag * dcr_pkg::SAMPLE_W'(dcr_pkg::DIV6_RECIP);
	assign quot     = div_prod[dcr_pkg::DIV6_SHIFT+dcr_pkg::SAMPLE_W-2:dcr_pkg::DIV6_SHIFT];

	always_comb begin
		if (scale_mode_q) begin
			scaled = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		end else begin
			scaled = mul11[dcr_pkg::SCALE_SHIFT+dcr_pkg::SAMPLE_W-1:dcr_pkg::SCALE_SHIFT];
		end
	end

	// mix back into each channel
	assign left_mix  = {{2{left_s2[dcr_pkg::SAMPLE_W-1]}}, left_s2} +
		{{2{scaled[dcr_pkg::SAMPLE_W-1]}}, scaled};
	assign right_mix = {{2{right_s2[dcr_pkg::SAMPLE_W-1]}}, right_s2} +
		{{2{scaled[dcr_pkg::SAMPLE_W-1]}}, scaled};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			left_s3  <= dcr_pkg::sat16(left_mix);
			right_s3 <= dcr_pkg::sat16(right_mix);
			last_s3  <= last_s2;
		end
	end

	assign out_ch.valid     = v_s3;
	assign out_ch.left_out  = left_s3;
	assign out_ch.right_out = right_s3;
	assign out_ch.last_out  = last_s3;

	`DCR_ASSERT_NEXT(a_widx_hold, !in_acc, $stable(widx_q), "write index moved without a word")
	`DCR_ASSERT_NEXT(a_wrap_sticky, wrapped_q, wrapped_q, "fill flag cleared outside reset")
	`DCR_ASSERT_NEXT(a_s1_to_s2, v_s1 && rdy_s2, v_s2, "word lost between stage one and two")

endmodule

// ===== verif/dcr_mix_checker.sv =====
`timescale 1ns / 1ps

module dcr_mix_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	dcr_in_if                              in_mon,
	dcr_out_if                             out_mon,
	input  logic                           cfg_we,
	input  logic [dcr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dcr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding
);
	import dcr_pkg::*;

	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    last;
	} mix_word_t;

	// expected output words, oldest first
	mix_word_t expected_mix[$];

	// shadow copy of both delay lines and low-pass memories
	sample_t            comb_line [2][DELAY_DEPTH];
	int                 comb_smooth [2];
	logic [DELAY_W-1:0] comb_delay [2];
	logic [GAIN_W-1:0]  fb_gain;
	logic               lp_on;
	logic               div6_mode;
	addr_t              wr_ptr;

	mix_word_t want;

	function automatic sample_t clamp16(input int x);
		if (x > 32767) begin
			return sample_t'(32767);
		end else if (x < -32768) begin
			return sample_t'(-32768);
		end
		return sample_t'(x);
	endfunction

	// one comb filter: read the delayed entry, add feedback, smooth, write back
	function automatic int comb_tap(input int k, input int mid, input bit quiet);
		addr_t rd;
		int    delayed;
		int    val;
		int    avg;
		rd = wr_ptr - addr_t'(comb_delay[k]);
		delayed = comb_line[k][rd];
		// silence: nothing delayed and nothing coming in
		if (delayed == 0 && quiet) begin
			comb_line[k][wr_ptr] = '0;
			comb_smooth[k] = 0;
			return 0;
		end
		if (delayed != 0) begin
			val = clamp16(mid + ((int'(fb_gain) * delayed) >>> FB_SHIFT));
		end else begin
			val = mid;
		end
		if (lp_on) begin
			avg = (comb_smooth[k] + val) >>> 1;
			comb_smooth[k] = val;
			val = avg;
		end
		comb_line[k][wr_ptr] = sample_t'(val);
		return val;
	endfunction

	// full sample step: mid value, both combs, scaling, mix into each channel
	function automatic mix_word_t predict_mix(input sample_t l, input sample_t r,
		input logic last);
		int        li;
		int        ri;
		int        mid;
		int        total;
		bit        quiet;
		mix_word_t w;
		li = l;
		ri = r;
		mid = (li + ri) >>> 1;
		quiet = (li == 0 && ri == 0);
		total = comb_tap(0, mid, quiet);
		total += comb_tap(1, mid, quiet);
		if (div6_mode) begin
			total = total / 6;
		end else begin
			total = (SCALE_MUL * total) >>> SCALE_SHIFT;
		end
		wr_ptr = wr_ptr + addr_t'(1);
		w.left = clamp16(li + total);
		w.right = clamp16(ri + total);
		w.last = last;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				for (int j = 0; j < DELAY_DEPTH; j++) begin
					comb_line[k][j] = '0;
				end
				comb_smooth[k] = 0;
				comb_delay[k] = DELAY_W'(1);
			end
			fb_gain = '0;
			lp_on = 1'b1;
			div6_mode = 1'b0;
			wr_ptr = '0;
			expected_mix.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_DELAY_A: comb_delay[0] = cfg_data[DELAY_W-1:0];
					REG_DELAY_B: comb_delay[1] = cfg_data[DELAY_W-1:0];
					REG_FB_GAIN: fb_gain = cfg_data[GAIN_W-1:0];
					REG_LP_EN: lp_on = cfg_data[0];
					REG_SCALE_MODE: div6_mode = cfg_data[0];
					default: ;
				endcase
			end

			// accepted input word
			if (in_mon.valid && in_mon.ready) begin
				expected_mix.push_back(predict_mix(in_mon.left_in, in_mon.right_in,
					in_mon.last_in));
			end

			// accepted output word against the oldest expectation
			if (out_mon.valid && out_mon.ready) begin
				if (expected_mix.size() == 0) begin
					$error("output word with no expectation: left_out %0d right_out %0d",
						$signed(out_mon.left_out), $signed(out_mon.right_out));
					mismatches++;
				end else begin
					want = expected_mix.pop_front();
					if (out_mon.left_out !== want.left) begin
						$error("left_out: expected %0d, got %0d", $signed(want.left),
							$signed(out_mon.left_out));
						mismatches++;
					end
					if (out_mon.right_out !== want.right) begin
						$error("right_out: expected %0d, got %0d", $signed(want.right),
							$signed(out_mon.right_out));
						mismatches++;
					end
					if (out_mon.last_out !== want.last) begin
						$error("last_out: expected %0d, got %0d", want.last,
							out_mon.last_out);
						mismatches++;
					end
				end
			end

			outstanding <= expected_mix.size();
		end
	end

endmodule

// ===== verif/tb_dual_comb_reverb_core.sv =====
`timescale 1ns / 1ps

module tb_dual_comb_reverb_core;
	import dcr_pkg::*;

	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_WORDS  = 170;
	localparam int ZERO_WORDS   = 50;
	localparam int HOLD_PHASE   = 2;
	localparam int FLAT_PHASE   = 5;

	typedef enum {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  stall_req = 1'b0;

	int mismatches;
	int outstanding;
	int cycle_count = 0;

	rx_mode_t rx_mode = RX_FREE;
	int       rx_left = 0;
	int       hold_count = 0;
	bit       hold_done = 1'b0;

	dcr_in_if  in_ch ();
	dcr_out_if out_ch ();

	dual_comb_reverb_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	dcr_mix_checker mix_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_mon      (in_ch),
		.out_mon     (out_ch),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("dual_comb_reverb_core: mismatch");
			$finish;
		end
	end

	// output side: one long hold on request, otherwise a changing ready pattern
	always @(posedge clk) begin
		if (stall_req && !hold_done) begin
			out_ch.ready <= 1'b0;
			hold_count++;
			if (hold_count >= LONG_HOLD) begin
				hold_done = 1'b1;
			end
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_left = $urandom_range(16, 200);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_FREE: out_ch.ready <= 1'b1;
				RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
				default: out_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// offer one word and hold it until taken
	task automatic push_word(input sample_t l, input sample_t r, input logic last);
		in_ch.valid <= 1'b1;
		in_ch.left_in <= l;
		in_ch.right_in <= r;
		in_ch.last_in <= last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
	endtask

	// gap between bursts, payload left as noise
	task automatic idle_for(input int n);
		if (n > 0) begin
			in_ch.valid <= 1'b0;
			in_ch.left_in <= sample_t'($urandom);
			in_ch.right_in <= sample_t'($urandom);
			in_ch.last_in <= 1'($urandom_range(0, 1));
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending and let every pending word come out
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// full register set, narrow registers get junk in the unused upper bits
	task automatic load_config(input logic [DELAY_W-1:0] da, input logic [DELAY_W-1:0] db,
		input logic [GAIN_W-1:0] g, input logic lp, input logic sm, input bit spare);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		wait_drained();
		write_reg(REG_DELAY_A, CFG_DATA_W'(da));
		write_reg(REG_DELAY_B, CFG_DATA_W'(db));
		write_reg(REG_FB_GAIN, {junk[CFG_DATA_W-1:GAIN_W], g});
		write_reg(REG_LP_EN, {junk[CFG_DATA_W-1:1], lp});
		write_reg(REG_SCALE_MODE, {junk[CFG_DATA_W-1:1], sm});
		if (spare) begin
			for (int k = int'(REG_SCALE_MODE) + 1; k < (1 << CFG_IDX_W); k++) begin
				write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
			end
		end
		cfg_we <= 1'b0;
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2, 3, 4: return sample_t'(int'($urandom_range(0, 512)) - 256);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [DELAY_W-1:0] pick_delay();
		case ($urandom_range(0, 7))
			0: return DELAY_W'(1);
			1: return {DELAY_W{1'b1}};
			2: return DELAY_W'($urandom_range(41, 2000));
			default: return DELAY_W'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return {GAIN_W{1'b1}};
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// random words, in bursts unless gapless, with occasional runs of silence
	task automatic run_phase(input int n, input bit gapless);
		int      burst_left;
		int      zero_run;
		sample_t l;
		sample_t r;
		burst_left = 0;
		zero_run = 0;
		for (int i = 0; i < n; i++) begin
			if (!gapless && burst_left <= 0) begin
				idle_for($urandom_range(0, 8));
				burst_left = $urandom_range(1, 32);
			end
			if (zero_run == 0 && $urandom_range(0, 39) == 0) begin
				zero_run = $urandom_range(1, 80);
			end
			if (zero_run > 0) begin
				l = '0;
				r = '0;
				zero_run--;
			end else begin
				l = pick_sample();
				r = pick_sample();
			end
			push_word(l, r, 1'($urandom_range(0, 1)));
			burst_left--;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.left_in = '0;
		in_ch.right_in = '0;
		in_ch.last_in = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: silence first, then the sample extremes and small values
		push_word('0, '0, 1'b0);
		push_word('0, '0, 1'b1);
		push_word(16'sh7fff, 16'sh7fff, 1'b1);
		push_word(16'sh8000, 16'sh8000, 1'b0);
		push_word(16'sh7fff, 16'sh8000, 1'b0);
		push_word(sample_t'(-1), '0, 1'b1);
		push_word(sample_t'(1), sample_t'(-1), 1'b0);
		push_word(16'sh8000, 16'sh7fff, 1'b1);

		// full feedback, short delays, no low-pass, divide by six
		load_config(DELAY_W'(1), DELAY_W'(2), {GAIN_W{1'b1}}, 1'b0, 1'b1, 1'b1);
		repeat (3) push_word(16'sh7fff, 16'sh7fff, 1'b0);
		repeat (3) push_word(16'sh8000, 16'sh8000, 1'b1);
		repeat (2) push_word('0, '0, 1'b0);
		push_word(sample_t'(-3), sample_t'(2), 1'b1);
		push_word(sample_t'(7), sample_t'(-9), 1'b0);

		// longest delay, half feedback, low-pass and shift scaling
		load_config({DELAY_W{1'b1}}, DELAY_W'(3), GAIN_W'(128), 1'b1, 1'b0, 1'b0);
		push_word(16'sh8000, 16'sh8000, 1'b0);
		push_word(16'sh7fff, 16'sh7fff, 1'b1);
		push_word('0, '0, 1'b0);
		push_word(sample_t'(5), sample_t'(-8), 1'b1);

		// random settings and traffic
		for (int p = 0; p < RAND_PHASES; p++) begin
			load_config(pick_delay(), pick_delay(), pick_gain(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'b0);
			if (p == HOLD_PHASE) begin
				stall_req <= 1'b1;
			end
			run_phase(PHASE_WORDS, p == HOLD_PHASE || p == FLAT_PHASE);
		end

		// zero delay reads only entries a full line old, none written yet
		load_config('0, {DELAY_W{1'b1}}, pick_gain(), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'b0);
		run_phase(ZERO_WORDS, 1'b1);

		// short delays to close
		load_config(DELAY_W'(1), DELAY_W'(3), pick_gain(), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'b0);
		run_phase(120, 1'b0);

		wait_drained();
		if (mismatches == 0) begin
			$display("dual_comb_reverb_core: match");
		end else begin
			$display("dual_comb_reverb_core: mismatch");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dcr_pkg.sv
rtl/core/dcr_in_if.sv
rtl/core/dcr_out_if.sv
rtl/core/dcr_ram.sv
rtl/core/dcr_comb.sv
rtl/core/dual_comb_reverb_core.sv
verif/dcr_mix_checker.sv
verif/tb_dual_comb_reverb_core.sv
